// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/tssc_pkg.sv =====
package tssc_pkg;

    localparam int VALUE_W = 10;
    localparam int OUT_W   = 9;
    localparam int CMD_W   = 2;
    localparam int SUM_W   = 11;

    localparam logic [CMD_W-1:0] CMD_ADD_I = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_J = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADD_K = 2'd2;
    localparam logic [CMD_W-1:0] CMD_EVAL  = 2'd3;

    localparam logic [1:0] SET_I = 2'd0;
    localparam logic [1:0] SET_J = 2'd1;
    localparam logic [1:0] SET_K = 2'd2;

    localparam logic [1:0] PAIR_IJ = 2'd0;
    localparam logic [1:0] PAIR_IK = 2'd1;
    localparam logic [1:0] PAIR_JK = 2'd2;

    localparam logic [OUT_W-1:0] OUT_MAX = 9'd511;

    typedef struct packed {
        logic [4:0]       pad;
        logic             overflow;
        logic [OUT_W-1:0] covered_prefix;
        logic [OUT_W-1:0] covered_count;
    } result_t;

endpackage

// ===== rtl/core/three_set_sumset_coverage.sv =====
// Collects elements into sets I, J and K (command 0, 1, 2) and, on an evaluate
// command (3), reports how many positions below HORIZON are covered by the pair
// sums I+J, I+K, or by two adjacent J+K sums, plus the covered run from zero and
// whether any add was dropped since the last evaluation. The sets live in one
// memory with two read ports and the sum bitmaps in a second memory of HORIZON
// entries. A clearing pass and a scan each walk the bitmap memory one entry a
// cycle, the pass through its write port and the scan through its read port; in
// between, the pair phase marks one element pair a cycle. No item is accepted
// during an evaluation; a finished result waits in an output register while
// adds are taken.
`include "assert_macros.svh"

module three_set_sumset_coverage #(
    parameter int HORIZON      = 511,
    parameter int MAX_ELEMENTS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // value [9:0], zero pad [15:10]
    input  logic [1:0]  s_tuser,   // command [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // covered_count [8:0], covered_prefix [17:9],
                                   // overflow [18], zero pad [23:19]
);

    localparam int IW  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW  = $clog2(MAX_ELEMENTS + 1);
    localparam int MW  = $clog2(HORIZON);
    localparam int AW  = $clog2(HORIZON + 1);
    localparam int SAW = IW + 2;
    localparam int SDEPTH = 3 * (1 << IW);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CLEAR  = 3'd1;
    localparam logic [2:0] ST_PAIR   = 3'd2;
    localparam logic [2:0] ST_PDRAIN = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;
    localparam logic [2:0] ST_SLAST  = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg [0:2];
    logic [CW-1:0] cnt_next [0:2];
    logic          lost_reg, lost_next;
    logic [1:0]    pair_reg, pair_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic          pv_reg, pv_next;
    logic [2:0]    pbit_reg, pbit_next;
    logic [MW-1:0] q_reg, q_next;
    logic          sv_reg, sv_next;
    logic          prev_jk_reg, prev_jk_next;
    logic          run_reg, run_next;
    logic [AW-1:0] acc_cnt_reg, acc_cnt_next;
    logic [AW-1:0] acc_pref_reg, acc_pref_next;
    logic          m_valid_reg, m_valid_next;
    tssc_pkg::result_t res_reg, res_next;

    logic [tssc_pkg::VALUE_W-1:0] set_mem [0:SDEPTH-1];
    logic [tssc_pkg::VALUE_W-1:0] rda_reg, rdb_reg;
    logic [2:0]                   map_mem [0:HORIZON-1];
    logic [2:0]                   map_rd_reg;

    logic                        in_fire;
    logic [1:0]                  asel, bsel;
    logic [CW-1:0]               na, nb;
    logic                        pair_empty, pair_last, j_wrap;
    logic                        set_we;
    logic [SAW-1:0]              set_waddr, addr_a, addr_b;
    logic [2:0]                  map_we, map_wdata;
    logic [MW-1:0]               map_waddr;
    logic [tssc_pkg::SUM_W-1:0]  sum;
    logic                        covered;
    logic [tssc_pkg::OUT_W-1:0]  cnt_out, pref_out;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = res_reg;

    // pair operand selection
    always_comb
    begin
        case (pair_reg)
            tssc_pkg::PAIR_IJ:
            begin
                asel = tssc_pkg::SET_I;
                bsel = tssc_pkg::SET_J;
            end
            tssc_pkg::PAIR_IK:
            begin
                asel = tssc_pkg::SET_I;
                bsel = tssc_pkg::SET_K;
            end
            default:
            begin
                asel = tssc_pkg::SET_J;
                bsel = tssc_pkg::SET_K;
            end
        endcase
    end

    assign na         = cnt_reg[asel];
    assign nb         = cnt_reg[bsel];
    assign pair_empty = (na == '0) || (nb == '0);
    assign j_wrap     = ((j_reg + CW'(1)) == nb);
    assign pair_last  = j_wrap && ((i_reg + CW'(1)) == na);
    assign addr_a     = {asel, i_reg[IW-1:0]};
    assign addr_b     = {bsel, j_reg[IW-1:0]};

    assign set_we    = in_fire && (s_tuser != tssc_pkg::CMD_EVAL)
                       && (cnt_reg[s_tuser] < CW'(MAX_ELEMENTS));
    assign set_waddr = {s_tuser, cnt_reg[s_tuser][IW-1:0]};

    assign sum = {1'b0, rda_reg} + {1'b0, rdb_reg};

    // bitmap write port: clearing pass or pair marking
    always_comb
    begin
        map_we    = 3'b000;
        map_wdata = 3'b111;
        map_waddr = q_reg;
        if (state_reg == ST_CLEAR)
        begin
            map_we    = 3'b111;
            map_wdata = 3'b000;
        end
        else if (pv_reg && (sum < tssc_pkg::SUM_W'(HORIZON)))
        begin
            map_we    = pbit_reg;
            map_waddr = sum[MW-1:0];
        end
    end

    assign covered = map_rd_reg[0] || map_rd_reg[1] || (prev_jk_reg && map_rd_reg[2]);

    // saturate to the output width
    assign cnt_out  = (tssc_pkg::SUM_W'(acc_cnt_reg) > tssc_pkg::SUM_W'(tssc_pkg::OUT_MAX))
                      ? tssc_pkg::OUT_MAX : tssc_pkg::OUT_W'(acc_cnt_reg);
    assign pref_out = (tssc_pkg::SUM_W'(acc_pref_reg) > tssc_pkg::SUM_W'(tssc_pkg::OUT_MAX))
                      ? tssc_pkg::OUT_MAX : tssc_pkg::OUT_W'(acc_pref_reg);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        lost_next     = lost_reg;
        pair_next     = pair_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        pv_next       = 1'b0;
        pbit_next     = pbit_reg;
        q_next        = q_reg;
        sv_next       = 1'b0;
        prev_jk_next  = prev_jk_reg;
        run_next      = run_reg;
        acc_cnt_next  = acc_cnt_reg;
        acc_pref_next = acc_pref_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        res_next      = res_reg;

        if (sv_reg)
        begin
            prev_jk_next = map_rd_reg[2];
            if (covered)
            begin
                acc_cnt_next = acc_cnt_reg + AW'(1);
                if (run_reg)
                begin
                    acc_pref_next = acc_pref_reg + AW'(1);
                end
            end
            else
            begin
                run_next = 1'b0;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_tuser == tssc_pkg::CMD_EVAL)
                    begin
                        state_next    = ST_CLEAR;
                        q_next        = '0;
                        pair_next     = tssc_pkg::PAIR_IJ;
                        i_next        = '0;
                        j_next        = '0;
                        prev_jk_next  = 1'b0;
                        run_next      = 1'b1;
                        acc_cnt_next  = '0;
                        acc_pref_next = '0;
                    end
                    else if (set_we)
                    begin
                        cnt_next[s_tuser] = cnt_reg[s_tuser] + CW'(1);
                    end
                    else
                    begin
                        lost_next = 1'b1;
                    end
                end
            end
            ST_CLEAR:
            begin
                if (q_reg == MW'(HORIZON - 1))
                begin
                    q_next     = '0;
                    state_next = ST_PAIR;
                end
                else
                begin
                    q_next = q_reg + MW'(1);
                end
            end
            ST_PAIR:
            begin
                pv_next = !pair_empty;
                case (pair_reg)
                    tssc_pkg::PAIR_IJ: pbit_next = 3'b001;
                    tssc_pkg::PAIR_IK: pbit_next = 3'b010;
                    default:           pbit_next = 3'b100;
                endcase
                if (pair_empty || pair_last)
                begin
                    i_next = '0;
                    j_next = '0;
                    if (pair_reg == tssc_pkg::PAIR_JK)
                    begin
                        state_next = ST_PDRAIN;
                    end
                    else
                    begin
                        pair_next = pair_reg + 2'd1;
                    end
                end
                else if (j_wrap)
                begin
                    j_next = '0;
                    i_next = i_reg + CW'(1);
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                end
            end
            ST_PDRAIN:
            begin
                state_next = ST_SCAN;
                q_next     = '0;
            end
            ST_SCAN:
            begin
                sv_next = 1'b1;
                if (q_reg == MW'(HORIZON - 1))
                begin
                    q_next     = '0;
                    state_next = ST_SLAST;
                end
                else
                begin
                    q_next = q_reg + MW'(1);
                end
            end
            ST_SLAST:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next            = 1'b1;
                    res_next.pad            = '0;
                    res_next.overflow       = lost_reg;
                    res_next.covered_prefix = pref_out;
                    res_next.covered_count  = cnt_out;
                    lost_next               = 1'b0;
                    cnt_next[0]             = '0;
                    cnt_next[1]             = '0;
                    cnt_next[2]             = '0;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg[0]  <= '0;
            cnt_reg[1]  <= '0;
            cnt_reg[2]  <= '0;
            lost_reg    <= 1'b0;
            pair_reg    <= tssc_pkg::PAIR_IJ;
            i_reg       <= '0;
            j_reg       <= '0;
            pv_reg      <= 1'b0;
            q_reg       <= '0;
            sv_reg      <= 1'b0;
            run_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            lost_reg    <= lost_next;
            pair_reg    <= pair_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            pv_reg      <= pv_next;
            q_reg       <= q_next;
            sv_reg      <= sv_next;
            run_reg     <= run_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pbit_reg     <= pbit_next;
        prev_jk_reg  <= prev_jk_next;
        acc_cnt_reg  <= acc_cnt_next;
        acc_pref_reg <= acc_pref_next;
        res_reg      <= res_next;
    end

    // set memory: one write port, two read ports
    always_ff @(posedge clk)
    begin
        if (set_we)
        begin
            set_mem[set_waddr] <= s_tdata[tssc_pkg::VALUE_W-1:0];
        end
        rda_reg <= set_mem[addr_a];
        rdb_reg <= set_mem[addr_b];
    end

    // sum bitmap memory with per-bit write enables
    always_ff @(posedge clk)
    begin
        for (int b = 0; b < 3; b++)
        begin
            if (map_we[b])
            begin
                map_mem[map_waddr][b] <= map_wdata[b];
            end
        end
        map_rd_reg <= map_mem[q_reg];
    end

    `ASSERT_CLK(a_eval_starts_clear, clk, rst_n,
        (in_fire && s_tuser == tssc_pkg::CMD_EVAL) |=> (state_reg == ST_CLEAR),
        "evaluate item did not start the clearing pass")

    `ASSERT_CLK(a_mark_only_in_pair, clk, rst_n,
        pv_reg |-> (state_reg == ST_PAIR || state_reg == ST_PDRAIN),
        "bitmap marking outside the pair phase")

    `ASSERT_CLK(a_prefix_le_count, clk, rst_n,
        m_valid_reg |-> (res_reg.covered_prefix <= res_reg.covered_count),
        "covered run longer than covered count")

    `ASSERT_ALWAYS(a_count_bounded, clk,
        (cnt_reg[0] <= CW'(MAX_ELEMENTS)) && (cnt_reg[1] <= CW'(MAX_ELEMENTS))
        && (cnt_reg[2] <= CW'(MAX_ELEMENTS)),
        "set count above capacity")

endmodule

// ===== verif/tb_three_set_sumset_coverage.sv =====
`timescale 1ns / 1ps

module tb_three_set_sumset_coverage;

    localparam int HORIZON      = 511;
    localparam int MAX_ELEMENTS = 32;
    localparam int ITEM_TARGET  = 1100;
    // longest evaluate: two bitmap passes plus every pair of three full sets
    localparam int DRAIN_CYCLES = 2 * HORIZON + 3 * MAX_ELEMENTS * MAX_ELEMENTS + 100;
    localparam int HOLD_CYCLES  = 8000;
    // every item an evaluate of full sets, with the longest gaps on both sides
    localparam int LIMIT        = 4 * (ITEM_TARGET + 50) * (DRAIN_CYCLES + 100)
                                  + HOLD_CYCLES;

    typedef struct packed {
        logic [tssc_pkg::CMD_W-1:0]   cmd;
        logic [tssc_pkg::VALUE_W-1:0] value;
    } op_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // value [9:0], zero pad [15:10]
    logic [1:0]  s_tuser;   // command [1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // covered_count [8:0], covered_prefix [17:9], overflow [18], pad

    three_set_sumset_coverage #(
        .HORIZON      (HORIZON),
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    op_t                          op_queue[$];
    tssc_pkg::result_t            cov_expected[$];
    logic [tssc_pkg::VALUE_W-1:0] set_elems[3][MAX_ELEMENTS];
    int                           set_fill[3];
    bit                           lost_pending;
    bit [2:0]                     pair_hits[HORIZON];

    int err_count    = 0;
    int cycles       = 0;
    int results_seen = 0;
    int n_adds       = 0;
    int n_evals      = 0;
    int n_lost       = 0;
    int max_cov      = 0;
    int max_pref     = 0;
    int gap_left     = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    bit in_taken     = 1'b0;
    bit steady       = 1'b0;
    bit hold_started = 1'b0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [tssc_pkg::CMD_W-1:0] add_cmd(input int set_idx);
        case (set_idx)
            0:       return tssc_pkg::CMD_ADD_I;
            1:       return tssc_pkg::CMD_ADD_J;
            default: return tssc_pkg::CMD_ADD_K;
        endcase
    endfunction

    task automatic push_op(input logic [tssc_pkg::CMD_W-1:0] cmd, input int value);
        op_t op;
        op.cmd   = cmd;
        op.value = tssc_pkg::VALUE_W'(value);
        op_queue.insert(op_queue.size(), op);
    endtask

    function automatic void mark_pairs(input int a, input int b, input int bit_idx);
        int s;
        for (int i = 0; i < set_fill[a]; i++)
            for (int j = 0; j < set_fill[b]; j++)
            begin
                s = int'(set_elems[a][i]) + int'(set_elems[b][j]);
                if (s < HORIZON)
                    pair_hits[s][bit_idx] = 1'b1;
            end
    endfunction

    task automatic apply_op(input logic [tssc_pkg::CMD_W-1:0] cmd,
                            input logic [tssc_pkg::VALUE_W-1:0] value);
        tssc_pkg::result_t r;
        int                set_idx;
        int                cnt;
        int                pref;
        bit                hit;
        if (cmd != tssc_pkg::CMD_EVAL)
        begin
            n_adds++;
            case (cmd)
                tssc_pkg::CMD_ADD_I: set_idx = int'(tssc_pkg::SET_I);
                tssc_pkg::CMD_ADD_J: set_idx = int'(tssc_pkg::SET_J);
                default:             set_idx = int'(tssc_pkg::SET_K);
            endcase
            if (set_fill[set_idx] < MAX_ELEMENTS)
            begin
                set_elems[set_idx][set_fill[set_idx]] = value;
                set_fill[set_idx]++;
            end
            else
            begin
                lost_pending = 1'b1;
            end
        end
        else
        begin
            n_evals++;
            foreach (pair_hits[q])
                pair_hits[q] = '0;
            mark_pairs(int'(tssc_pkg::SET_I), int'(tssc_pkg::SET_J), int'(tssc_pkg::PAIR_IJ));
            mark_pairs(int'(tssc_pkg::SET_I), int'(tssc_pkg::SET_K), int'(tssc_pkg::PAIR_IK));
            mark_pairs(int'(tssc_pkg::SET_J), int'(tssc_pkg::SET_K), int'(tssc_pkg::PAIR_JK));
            cnt  = 0;
            pref = 0;
            for (int q = 0; q < HORIZON; q++)
            begin
                hit = pair_hits[q][tssc_pkg::PAIR_IJ] | pair_hits[q][tssc_pkg::PAIR_IK];
                if (!hit && q > 0 && pair_hits[q-1][tssc_pkg::PAIR_JK]
                    && pair_hits[q][tssc_pkg::PAIR_JK])
                    hit = 1'b1;
                if (hit)
                begin
                    cnt++;
                    if (pref == q)
                        pref++;
                end
            end
            if (cnt > int'(tssc_pkg::OUT_MAX))
                cnt = int'(tssc_pkg::OUT_MAX);
            if (pref > int'(tssc_pkg::OUT_MAX))
                pref = int'(tssc_pkg::OUT_MAX);
            if (cnt > max_cov)
                max_cov = cnt;
            if (pref > max_pref)
                max_pref = pref;
            if (lost_pending)
                n_lost++;
            r                = '0;
            r.covered_count  = tssc_pkg::OUT_W'(cnt);
            r.covered_prefix = tssc_pkg::OUT_W'(pref);
            r.overflow       = lost_pending;
            cov_expected.insert(cov_expected.size(), r);
            foreach (set_fill[k])
                set_fill[k] = 0;
            lost_pending = 1'b0;
        end
    endtask

    task automatic report(input string what, input int got, input int want);
        err_count++;
        if (err_count <= 50)
            $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    endtask

    task automatic build_directed();
        // empty sets
        push_op(tssc_pkg::CMD_EVAL, 0);
        // smallest sum
        push_op(tssc_pkg::CMD_ADD_I, 0);
        push_op(tssc_pkg::CMD_ADD_J, 0);
        push_op(tssc_pkg::CMD_EVAL, 1023);
        // all sums past the horizon
        push_op(tssc_pkg::CMD_ADD_I, 1023);
        push_op(tssc_pkg::CMD_ADD_J, 1023);
        push_op(tssc_pkg::CMD_ADD_K, 1023);
        push_op(tssc_pkg::CMD_EVAL, 0);
        // sum just below and just at the horizon
        push_op(tssc_pkg::CMD_ADD_I, 0);
        push_op(tssc_pkg::CMD_ADD_J, HORIZON - 1);
        push_op(tssc_pkg::CMD_ADD_K, HORIZON);
        push_op(tssc_pkg::CMD_EVAL, 0);
        // adjacent j+k sums with a duplicate element
        push_op(tssc_pkg::CMD_ADD_J, 3);
        push_op(tssc_pkg::CMD_ADD_K, 4);
        push_op(tssc_pkg::CMD_ADD_K, 5);
        push_op(tssc_pkg::CMD_ADD_J, 3);
        push_op(tssc_pkg::CMD_EVAL, 0);
        // covered run from zero through the I+K and I+J pairs
        push_op(tssc_pkg::CMD_ADD_I, 0);
        push_op(tssc_pkg::CMD_ADD_I, 1);
        push_op(tssc_pkg::CMD_ADD_K, 0);
        push_op(tssc_pkg::CMD_ADD_J, 2);
        push_op(tssc_pkg::CMD_EVAL, 682);
    endtask

    task automatic build_random();
        int total;
        int kind;
        int lim;
        int pick;
        int full_set;
        int n;
        int left[3];
        total = op_queue.size();
        while (total < ITEM_TARGET)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 84)
            begin
                pick = $urandom_range(0, 99);
                lim  = (pick < 50) ? 63 : (pick < 85) ? 255 : 1023;
                if (kind < 79)
                begin
                    foreach (left[s])
                        left[s] = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12)
                                                               : $urandom_range(0, 6);
                end
                else
                begin
                    // one or more sets filled near or past capacity
                    full_set = $urandom_range(0, 2);
                    foreach (left[s])
                        left[s] = (s == full_set || $urandom_range(0, 3) == 0)
                                  ? $urandom_range(MAX_ELEMENTS - 2, MAX_ELEMENTS + 4)
                                  : $urandom_range(0, 4);
                end
                while (left[0] + left[1] + left[2] > 0)
                begin
                    pick = $urandom_range(0, 2);
                    if (left[pick] > 0)
                    begin
                        push_op(add_cmd(pick), $urandom_range(0, lim));
                        left[pick]--;
                        total++;
                    end
                end
                push_op(tssc_pkg::CMD_EVAL, $urandom_range(0, 1023));
                total++;
            end
            else
            begin
                n = $urandom_range(1, 8);
                repeat (n)
                begin
                    push_op(tssc_pkg::CMD_W'($urandom_range(0, 3)), $urandom_range(0, 1023));
                    total++;
                end
            end
        end
        push_op(tssc_pkg::CMD_EVAL, 0);
    endtask

    // input side
    always @(negedge clk)
    begin
        op_t nxt;
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (gap_left > 0)
            begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (op_queue.size() > 0)
            begin
                nxt = op_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {6'b0, nxt.value};
                s_tuser  <= nxt.cmd;
                gap_left <= pick_gap();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output side
    always @(negedge clk)
    begin
        if (!rst_n || hold_left > 0)
        begin
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready   <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // one long hold-off on the output so the block backs up
    always @(negedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (!hold_started && results_seen >= 15)
        begin
            hold_started <= 1'b1;
            hold_left    <= HOLD_CYCLES;
        end
    end

    always @(posedge clk)
    begin
        tssc_pkg::result_t got;
        tssc_pkg::result_t want;
        in_taken <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = tssc_pkg::result_t'(m_tdata);
                results_seen++;
                if (cov_expected.size() == 0)
                begin
                    report("result with nothing pending", int'(got.covered_count), 0);
                end
                else
                begin
                    want = cov_expected.pop_front();
                    if (got.covered_count !== want.covered_count)
                        report("covered_count", int'(got.covered_count),
                               int'(want.covered_count));
                    if (got.covered_prefix !== want.covered_prefix)
                        report("covered_prefix", int'(got.covered_prefix),
                               int'(want.covered_prefix));
                    if (got.overflow !== want.overflow)
                        report("overflow", int'(got.overflow), int'(want.overflow));
                end
            end
            if (s_tvalid && s_tready)
                apply_op(s_tuser, s_tdata[tssc_pkg::VALUE_W-1:0]);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles % 2500 == 0)
            steady = ($urandom_range(0, 3) == 0);
        if (cycles >= LIMIT)
        begin
            $display("timeout at cycle %0d, %0d results outstanding", cycles,
                     cov_expected.size());
            $display("FAIL three_set_sumset_coverage");
            $finish;
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        lost_pending = 1'b0;
        foreach (set_fill[k])
            set_fill[k] = 0;
        build_directed();
        build_random();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (op_queue.size() > 0 || s_tvalid)
            @(negedge clk);
        while (cov_expected.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("run took %0d adds and %0d evaluations, %0d of them with dropped elements",
                 n_adds, n_evals, n_lost);
        $display("largest covered count %0d, longest covered run from zero %0d",
                 max_cov, max_pref);
        if (err_count == 0)
            $display("PASS three_set_sumset_coverage");
        else
            $display("FAIL three_set_sumset_coverage");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tssc_pkg.sv
rtl/core/three_set_sumset_coverage.sv
verif/tb_three_set_sumset_coverage.sv
